>>> hdl/vertex_attribute_dedup_table_top_macros.svh
// Assertion macros used by the vertex dedup table checker.
`ifndef VERTEX_ATTRIBUTE_DEDUP_TABLE_TOP_MACROS_SVH
`define VERTEX_ATTRIBUTE_DEDUP_TABLE_TOP_MACROS_SVH

// Clocked property, ignored while reset is high.
`define VADT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked through reset as well.
`define VADT_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/vadt_pkg.sv
// Package: sizes, codes and state type of the vertex dedup table.
package vadt_pkg;

   localparam int unsigned POINT_COUNT     = 1024;
   localparam int unsigned SLOTS_PER_POINT = 8;
   localparam int unsigned MAX_VERTICES    = 65536;

   localparam int POINT_W = 10;
   localparam int ATTR_W  = 16;
   localparam int KEY_W   = 4 * ATTR_W;
   localparam int VN_W    = 16;
   localparam int NV_W    = 17;
   localparam int FILL_W  = 4;
   localparam int ENTRY_W = VN_W + KEY_W;

   localparam int PT_W   = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;
   localparam int SLOT_W = (SLOTS_PER_POINT > 1) ? $clog2(SLOTS_PER_POINT) : 1;
   localparam int KEY_AW = PT_W + SLOT_W;
   localparam int KEY_DEPTH = 1 << KEY_AW;
   localparam int CLR_W  = $clog2(POINT_COUNT + 1);

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_NORMAL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_UV      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_TANGENT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_COLOR   = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_SCAN,
      ST_CMP,
      ST_DONE
   } state_type;

endpackage

>>> hdl/vadt_if.sv
// Interfaces: corner request, vertex response and register write channels.
interface vadt_req_if;
   import vadt_pkg::*;
   logic                valid;
   logic                ready;
   logic [POINT_W-1:0]  point_index;
   logic [ATTR_W-1:0]   normal_index;
   logic [ATTR_W-1:0]   uv_index;
   logic [ATTR_W-1:0]   tangent_index;
   logic [ATTR_W-1:0]   color_index;
   modport source (output valid, point_index, normal_index, uv_index, tangent_index,
                   color_index, input ready);
   modport sink   (input valid, point_index, normal_index, uv_index, tangent_index,
                   color_index, output ready);
endinterface

interface vadt_rsp_if;
   import vadt_pkg::*;
   logic             valid;
   logic             ready;
   logic [VN_W-1:0]  vertex_number;
   logic             is_new;
   logic             overflow;
   modport source (output valid, vertex_number, is_new, overflow, input ready);
   modport sink   (input valid, vertex_number, is_new, overflow, output ready);
endinterface

interface vadt_csr_if;
   import vadt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic                  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/vadt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vadt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/vertex_attribute_dedup_table_top.sv
// Top level: per-point attribute tuple table that hands out deduplicated vertex numbers.
//
//   channel | dir | beat
//   req_ch  | in  | point_index, normal/uv/tangent/color index of one corner
//   rsp_ch  | out | vertex_number, is_new, overflow
//   csr_ch  | in  | index, data: enable bit of one attribute
//
// An item runs from the request beat through the fill-count read, the slot scan and compare
// steps and the done step to the response beat; one comparator walks the bucket one slot
// per RAM read. After reset the fill count of every point is cleared before the first
// corner is taken. A stalled response holds; the next corner runs meanwhile and waits
// in its final step until the response register is free.
module vertex_attribute_dedup_table_top (
   input logic        clock,
   input logic        reset,
   vadt_req_if.sink   req_ch,
   vadt_rsp_if.source rsp_ch,
   vadt_csr_if.sink   csr_ch
);
   import vadt_pkg::*;

   state_type            state_ff, state_in;
   logic [CLR_W-1:0]     clr_ff, clr_in;
   logic [POINT_W-1:0]   point_ff, point_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [FILL_W-1:0]    slot_ff, slot_in;
   logic [NV_W-1:0]      next_vertex_ff, next_vertex_in;
   logic [VN_W-1:0]      res_vnum_ff, res_vnum_in;
   logic                 res_new_ff, res_new_in;
   logic                 res_ovf_ff, res_ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VN_W-1:0]      rsp_vnum_ff, rsp_vnum_in;
   logic                 rsp_new_ff, rsp_new_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;
   logic                 use_normal_ff, use_uv_ff, use_tangent_ff, use_color_ff;

   logic [KEY_W-1:0]     mask;
   logic [KEY_W-1:0]     req_key;
   logic [FILL_W-1:0]    fill_rd;
   logic                 fill_we, fill_re;
   logic [PT_W-1:0]      fill_wa, fill_ra;
   logic [FILL_W-1:0]    fill_wd;
   logic                 key_we, key_re;
   logic [KEY_AW-1:0]    key_wa, key_ra;
   logic [ENTRY_W-1:0]   key_wd, key_rd;

   assign mask = {{ATTR_W{use_color_ff}}, {ATTR_W{use_tangent_ff}},
                  {ATTR_W{use_uv_ff}}, {ATTR_W{use_normal_ff}}};
   assign req_key = {req_ch.color_index, req_ch.tangent_index,
                     req_ch.uv_index, req_ch.normal_index} & mask;

   vadt_ram #(.WIDTH(FILL_W), .DEPTH(POINT_COUNT)) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (fill_wa),
      .wr_data (fill_wd),
      .rd_en   (fill_re),
      .rd_addr (fill_ra),
      .rd_data (fill_rd)
   );

   vadt_ram #(.WIDTH(ENTRY_W), .DEPTH(KEY_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_wa),
      .wr_data (key_wd),
      .rd_en   (key_re),
      .rd_addr (key_ra),
      .rd_data (key_rd)
   );

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      point_in       = point_ff;
      key_in         = key_ff;
      fill_in        = fill_ff;
      slot_in        = slot_ff;
      next_vertex_in = next_vertex_ff;
      res_vnum_in    = res_vnum_ff;
      res_new_in     = res_new_ff;
      res_ovf_in     = res_ovf_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_vnum_in    = rsp_vnum_ff;
      rsp_new_in     = rsp_new_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      req_ch.ready   = 1'b0;
      fill_we        = 1'b0;
      fill_wa        = point_ff[PT_W-1:0];
      fill_wd        = fill_ff + FILL_W'(1);
      fill_re        = 1'b0;
      fill_ra        = req_ch.point_index[PT_W-1:0];
      key_we         = 1'b0;
      key_wa         = {point_ff[PT_W-1:0], fill_ff[SLOT_W-1:0]};
      key_wd         = {next_vertex_ff[VN_W-1:0], key_ff};
      key_re         = 1'b0;
      key_ra         = {point_ff[PT_W-1:0], slot_ff[SLOT_W-1:0]};

      case (state_ff)
         ST_CLEAR: begin
            fill_we = 1'b1;
            fill_wa = clr_ff[PT_W-1:0];
            fill_wd = '0;
            clr_in  = clr_ff + CLR_W'(1);
            if (clr_ff == CLR_W'(POINT_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               point_in = req_ch.point_index;
               key_in   = req_key;
               slot_in  = '0;
               fill_re  = 1'b1;
               if (int'(req_ch.point_index) < int'(POINT_COUNT)) begin
                  state_in = ST_FILL;
               end else begin
                  res_vnum_in = '0;
                  res_new_in  = 1'b0;
                  res_ovf_in  = 1'b1;
                  state_in    = ST_DONE;
               end
            end
         end
         ST_FILL: begin
            if (fill_rd > FILL_W'(SLOTS_PER_POINT)) begin
               fill_in = FILL_W'(SLOTS_PER_POINT);
            end else begin
               fill_in = fill_rd;
            end
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (slot_ff < fill_ff) begin
               key_re   = 1'b1;
               state_in = ST_CMP;
            end else begin
               state_in = ST_DONE;
               if (fill_ff >= FILL_W'(SLOTS_PER_POINT) ||
                   next_vertex_ff >= NV_W'(MAX_VERTICES)) begin
                  res_vnum_in = '0;
                  res_new_in  = 1'b0;
                  res_ovf_in  = 1'b1;
               end else begin
                  key_we         = 1'b1;
                  fill_we        = 1'b1;
                  res_vnum_in    = next_vertex_ff[VN_W-1:0];
                  res_new_in     = 1'b1;
                  res_ovf_in     = 1'b0;
                  next_vertex_in = next_vertex_ff + NV_W'(1);
               end
            end
         end
         ST_CMP: begin
            if ((key_rd[KEY_W-1:0] & mask) == key_ff) begin
               res_vnum_in = key_rd[ENTRY_W-1:KEY_W];
               res_new_in  = 1'b0;
               res_ovf_in  = 1'b0;
               state_in    = ST_DONE;
            end else begin
               slot_in  = slot_ff + FILL_W'(1);
               state_in = ST_SCAN;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_vnum_in  = res_vnum_ff;
               rsp_new_in   = res_new_ff;
               rsp_ovf_in   = res_ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         next_vertex_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         use_normal_ff  <= 1'b1;
         use_uv_ff      <= 1'b1;
         use_tangent_ff <= 1'b0;
         use_color_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         next_vertex_ff <= next_vertex_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_ch.valid) begin
            case (csr_ch.index)
               CSR_USE_NORMAL:  use_normal_ff  <= csr_ch.data;
               CSR_USE_UV:      use_uv_ff      <= csr_ch.data;
               CSR_USE_TANGENT: use_tangent_ff <= csr_ch.data;
               CSR_USE_COLOR:   use_color_ff   <= csr_ch.data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      point_ff    <= point_in;
      key_ff      <= key_in;
      fill_ff     <= fill_in;
      slot_ff     <= slot_in;
      res_vnum_ff <= res_vnum_in;
      res_new_ff  <= res_new_in;
      res_ovf_ff  <= res_ovf_in;
      rsp_vnum_ff <= rsp_vnum_in;
      rsp_new_ff  <= rsp_new_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign csr_ch.ready         = 1'b1;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.vertex_number = rsp_vnum_ff;
   assign rsp_ch.is_new        = rsp_new_ff;
   assign rsp_ch.overflow      = rsp_ovf_ff;
endmodule

>>> hdl/vadt_checker.sv
// Checker on the top-level ports of the vertex dedup table, with its bind.
`include "vertex_attribute_dedup_table_top_macros.svh"

module vadt_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [vadt_pkg::VN_W-1:0] rsp_vertex_number,
   input logic                    rsp_is_new,
   input logic                    rsp_overflow
);
   import vadt_pkg::*;

   logic req_beat;
   assign req_beat = req_valid && req_ready;

   `VADT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped before taken")
   `VADT_ASSERT(a_ovf_clean, clock, reset, rsp_valid && rsp_overflow |-> rsp_vertex_number == '0 && !rsp_is_new, "overflow beat carries a vertex")
   `VADT_ASSERT(a_busy_after_beat, clock, reset, req_beat |=> !req_ready, "request taken while a corner is in work")
   `VADT_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid && !req_ready, "channels active right after reset")
endmodule

bind vertex_attribute_dedup_table_top vadt_checker u_vadt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_vertex_number (rsp_ch.vertex_number),
   .rsp_is_new        (rsp_ch.is_new),
   .rsp_overflow      (rsp_ch.overflow)
);

>>> bench/vertex_attribute_dedup_table_top_tb.sv
`timescale 1ns / 100ps
// Testbench: drives corners and enable writes into the vertex dedup table and checks every vertex beat.
module vertex_attribute_dedup_table_top_tb;
   import vadt_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 12;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_LIMIT  = 4000;
   localparam int HOT_POINTS   = 16;
   localparam int PALETTE_SIZE = 4;

   typedef struct packed {
      logic [POINT_W-1:0] point;
      logic [ATTR_W-1:0]  normal;
      logic [ATTR_W-1:0]  uv;
      logic [ATTR_W-1:0]  tangent;
      logic [ATTR_W-1:0]  color;
   } corner_type;

   typedef struct packed {
      logic [VN_W-1:0] vertex_number;
      logic            is_new;
      logic            overflow;
   } vertex_result_type;

   logic clock = 1'b0;
   logic reset;

   vadt_req_if req_ch ();
   vadt_rsp_if rsp_ch ();
   vadt_csr_if csr_ch ();

   vertex_attribute_dedup_table_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Mirror of the table
   logic [KEY_W-1:0]  tuple_store [KEY_DEPTH];
   logic [VN_W-1:0]   slot_vertex [KEY_DEPTH];
   logic [FILL_W-1:0] bucket_used [POINT_COUNT];
   logic [NV_W-1:0]   next_vertex;
   logic [3:0]        attr_enable;

   vertex_result_type pending_vertices[$];
   int unsigned    mismatch_count = 0;
   int unsigned    quiet_cycles = 0;
   int unsigned    send_idle_pct = 0;
   int unsigned    rsp_stall_pct = 0;
   logic           hold_request = 1'b0;

   logic [POINT_W-1:0] hot_points [HOT_POINTS];
   logic [ATTR_W-1:0]  palette [PALETTE_SIZE];

   always #HALF_PERIOD clock = ~clock;

   function automatic vertex_result_type resolve_corner(input corner_type c);
      vertex_result_type r;
      logic [KEY_W-1:0] mask;
      logic [KEY_W-1:0] key;
      int unsigned used;
      int unsigned base;
      mask = '0;
      if (attr_enable[CSR_USE_NORMAL])  mask[ATTR_W-1:0] = '1;
      if (attr_enable[CSR_USE_UV])      mask[2*ATTR_W-1:ATTR_W] = '1;
      if (attr_enable[CSR_USE_TANGENT]) mask[3*ATTR_W-1:2*ATTR_W] = '1;
      if (attr_enable[CSR_USE_COLOR])   mask[4*ATTR_W-1:3*ATTR_W] = '1;
      key = {c.color, c.tangent, c.uv, c.normal} & mask;
      r.vertex_number = '0;
      r.is_new = 1'b0;
      r.overflow = 1'b1;
      if (c.point >= POINT_COUNT) return r;
      used = bucket_used[c.point];
      if (used > SLOTS_PER_POINT) used = SLOTS_PER_POINT;
      base = c.point * SLOTS_PER_POINT;
      for (int s = 0; s < used; s++) begin
         if ((tuple_store[base + s] & mask) == key) begin
            r.vertex_number = slot_vertex[base + s];
            r.overflow = 1'b0;
            return r;
         end
      end
      if (used >= SLOTS_PER_POINT || next_vertex >= MAX_VERTICES) return r;
      tuple_store[base + used] = key;
      slot_vertex[base + used] = next_vertex[VN_W-1:0];
      bucket_used[c.point] = FILL_W'(used + 1);
      r.vertex_number = next_vertex[VN_W-1:0];
      r.is_new = 1'b1;
      r.overflow = 1'b0;
      next_vertex = next_vertex + 1'b1;
      return r;
   endfunction

   function automatic corner_type random_corner();
      corner_type c;
      if ($urandom_range(99) < 75) begin
         c.point   = hot_points[$urandom_range(HOT_POINTS - 1)];
         c.normal  = palette[$urandom_range(PALETTE_SIZE - 1)];
         c.uv      = palette[$urandom_range(PALETTE_SIZE - 1)];
         c.tangent = palette[$urandom_range(PALETTE_SIZE - 1)];
         c.color   = palette[$urandom_range(PALETTE_SIZE - 1)];
      end else begin
         c.point   = POINT_W'($urandom);
         c.normal  = ATTR_W'($urandom);
         c.uv      = ATTR_W'($urandom);
         c.tangent = ATTR_W'($urandom);
         c.color   = ATTR_W'($urandom);
      end
      return c;
   endfunction

   function automatic corner_type make_corner(input logic [POINT_W-1:0] p,
                                              input logic [ATTR_W-1:0] n,
                                              input logic [ATTR_W-1:0] u,
                                              input logic [ATTR_W-1:0] t,
                                              input logic [ATTR_W-1:0] k);
      corner_type c;
      c.point = p;
      c.normal = n;
      c.uv = u;
      c.tangent = t;
      c.color = k;
      return c;
   endfunction

   task automatic send_corner(input corner_type c);
      int unsigned gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.point_index   = c.point;
      req_ch.normal_index  = c.normal;
      req_ch.uv_index      = c.uv;
      req_ch.tangent_index = c.tangent;
      req_ch.color_index   = c.color;
      req_ch.valid         = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_enable(input logic [CSR_IDX_W-1:0] idx, input logic value);
      @(negedge clock);
      csr_ch.index = idx;
      csr_ch.data  = value;
      csr_ch.valid = 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      attr_enable[idx] = value;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic apply_enables(input logic [3:0] en);
      drain_results();
      write_enable(CSR_USE_NORMAL,  en[CSR_USE_NORMAL]);
      write_enable(CSR_USE_UV,      en[CSR_USE_UV]);
      write_enable(CSR_USE_TANGENT, en[CSR_USE_TANGENT]);
      write_enable(CSR_USE_COLOR,   en[CSR_USE_COLOR]);
   endtask

   task automatic test_directed_corners();
      send_corner(make_corner('0, '0, '0, '0, '0));
      send_corner(make_corner('0, '0, '0, '0, '0));
      send_corner(make_corner('1, '1, '1, '1, '1));
      send_corner(make_corner('1, '1, '1, '0, '0));
      send_corner(make_corner('1, '1, 16'hFFFE, '1, '1));
      // fill one bucket, overflow it, then hit inside the full bucket
      for (int i = 0; i < SLOTS_PER_POINT; i++)
         send_corner(make_corner(10'd5, ATTR_W'(i), ~ATTR_W'(i), '0, '0));
      send_corner(make_corner(10'd5, 16'h00AA, 16'h5555, '0, '0));
      send_corner(make_corner(10'd5, ATTR_W'(SLOTS_PER_POINT - 1),
                              ~ATTR_W'(SLOTS_PER_POINT - 1), '0, '0));
      send_corner(make_corner(10'd5, '0, '1, 16'h1234, 16'h4321));
      drain_results();
   endtask

   task automatic test_enable_changes();
      apply_enables(4'b1111);
      send_corner(make_corner(10'd3, 16'd1, 16'd2, 16'd3, 16'd4));
      send_corner(make_corner(10'd3, 16'd1, 16'd2, 16'd3, 16'd5));
      send_corner(make_corner(10'd3, 16'd1, 16'd2, 16'd3, 16'd4));
      apply_enables(4'b0000);
      send_corner(make_corner(10'd3, 16'hDEAD, 16'hBEEF, 16'hCAFE, 16'hF00D));
      send_corner(make_corner(10'd9, 16'h8001, 16'h7FFE, 16'h0F0F, 16'hF0F0));
      send_corner(make_corner(10'd9, '0, '0, '0, '0));
      apply_enables(4'b0001);
      send_corner(make_corner(10'd11, 16'd5, 16'd9, 16'd7, 16'd8));
      apply_enables(4'b0011);
      send_corner(make_corner(10'd11, 16'd5, 16'd0, 16'd7, 16'd8));
      send_corner(make_corner(10'd11, 16'd5, 16'd9, 16'd7, 16'd8));
      drain_results();
   endtask

   task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
                                      input int unsigned stall_pct, input logic [3:0] en);
      apply_enables(en);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      foreach (hot_points[i]) hot_points[i] = POINT_W'($urandom);
      foreach (palette[i]) palette[i] = ATTR_W'($urandom);
      palette[0] = '0;
      palette[PALETTE_SIZE - 1] = '1;
      repeat (count) send_corner(random_corner());
      drain_results();
   endtask

   task automatic test_input_stall();
      apply_enables(4'b0011);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      foreach (hot_points[i]) hot_points[i] = POINT_W'($urandom);
      hold_request = 1'b1;
      repeat (60) send_corner(random_corner());
      drain_results();
   endtask

   // Receiver: random stalls, or one long hold when asked
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ch.ready = ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      corner_type c;
      if (!reset && req_ch.valid && req_ch.ready) begin
         c.point   = req_ch.point_index;
         c.normal  = req_ch.normal_index;
         c.uv      = req_ch.uv_index;
         c.tangent = req_ch.tangent_index;
         c.color   = req_ch.color_index;
         pending_vertices = {pending_vertices, resolve_corner(c)};
      end
   end

   always @(posedge clock) begin
      vertex_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_vertices.size() == 0) begin
            $error("vertex beat with nothing pending: vertex_number %0d", rsp_ch.vertex_number);
            mismatch_count++;
         end else begin
            want = pending_vertices.pop_front();
            if (rsp_ch.vertex_number !== want.vertex_number) begin
               $error("vertex_number: expected %0d, got %0d", want.vertex_number,
                      rsp_ch.vertex_number);
               mismatch_count++;
            end
            if (rsp_ch.is_new !== want.is_new) begin
               $error("is_new: expected %0b, got %0b", want.is_new, rsp_ch.is_new);
               mismatch_count++;
            end
            if (rsp_ch.overflow !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_ch.overflow);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("vertex_attribute_dedup_table_top_tb: done, errors");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.point_index = '0;
      req_ch.normal_index = '0;
      req_ch.uv_index = '0;
      req_ch.tangent_index = '0;
      req_ch.color_index = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_USE_NORMAL;
      csr_ch.data = 1'b0;
      foreach (bucket_used[i]) bucket_used[i] = '0;
      next_vertex = '0;
      attr_enable = '0;
      attr_enable[CSR_USE_NORMAL] = 1'b1;
      attr_enable[CSR_USE_UV] = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_corners();
      test_enable_changes();
      test_random_traffic(300, 0, 0, 4'b0011);
      test_random_traffic(300, 62, 0, 4'b1111);
      test_random_traffic(300, 0, 62, 4'($urandom));
      test_random_traffic(300, 33, 33, 4'b0101);
      test_input_stall();

      if (mismatch_count == 0) begin
         $display("vertex_attribute_dedup_table_top_tb: done, clean");
      end else begin
         $display("vertex_attribute_dedup_table_top_tb: done, errors");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/vadt_pkg.sv
hdl/vadt_if.sv
hdl/vadt_ram.sv
hdl/vertex_attribute_dedup_table_top.sv
hdl/vadt_checker.sv
bench/vertex_attribute_dedup_table_top_tb.sv
